/* rtl/vn3_pkg.sv */
// shared constants and types for the 3d value noise block
`default_nettype none

package vn3_pkg;

  // fixed field widths
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned NOISE_W   = 24;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // lattice axis multipliers
  localparam logic [HASH_W-1:0] AXIS_K_X = 32'h27d4eb2d;
  localparam logic [HASH_W-1:0] AXIS_K_Y = 32'h165667b1;
  localparam logic [HASH_W-1:0] AXIS_K_Z = 32'h9e3779b9;

  // avalanche mixer constants
  localparam logic [HASH_W-1:0] MIX_C1 = 32'h7feb352d;
  localparam logic [HASH_W-1:0] MIX_C2 = 32'h846ca68b;
  localparam int unsigned MIX_SH1 = 16;
  localparam int unsigned MIX_SH2 = 15;
  localparam int unsigned MIX_SH3 = 16;

  // advance strobes for the two register stages of one hash round
  typedef struct packed {
    logic mul1_en;
    logic mul2_en;
  } vn3_stage_en_t;

endpackage

`default_nettype wire

/* rtl/vn3_if.sv */
// request channels: point input, noise output and seed write
`default_nettype none

interface vn3_in_if import vn3_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic signed [COORD_W-1:0]  coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z, output ready);
endinterface

interface vn3_out_if import vn3_pkg::*;;
  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

interface vn3_cfg_if import vn3_pkg::*;;
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] noise_seed;

  modport source (output valid, output noise_seed, input ready);
  modport sink   (input valid, input noise_seed, output ready);
endinterface

`default_nettype wire

/* rtl/vn3_hash_round.sv */
// one avalanche hash round, two multiply stages, final xor-shift at the output
`default_nettype none

module vn3_hash_round import vn3_pkg::*; (
  input  wire logic                clk_i,
  input  wire vn3_stage_en_t       en_i,
  input  wire logic [HASH_W-1:0]   a_i,
  output logic      [HASH_W-1:0]   h_o
);

  logic [HASH_W-1:0] pre_a;
  logic [HASH_W-1:0] pre_b;
  logic [HASH_W-1:0] m1_q;
  logic [HASH_W-1:0] m2_q;

  // first xor-shift and multiply
  assign pre_a = a_i ^ (a_i >> MIX_SH1);

  always_ff @(posedge clk_i) begin
    if (en_i.mul1_en) begin
      m1_q <= pre_a * MIX_C1;
    end
  end

  // second xor-shift and multiply
  assign pre_b = m1_q ^ (m1_q >> MIX_SH2);

  always_ff @(posedge clk_i) begin
    if (en_i.mul2_en) begin
      m2_q <= pre_b * MIX_C2;
    end
  end

  // closing xor-shift
  assign h_o = m2_q ^ (m2_q >> MIX_SH3);

endmodule

`default_nettype wire

/* rtl/value_noise_3d_core.sv */
// top level: pipelined 3d value noise, smoothstep weights, trilinear blend
//
// Usage
//   in_if  : one 3d point per request, signed fixed point with FRAC_BITS
//            fraction bits in coord_x, coord_y, coord_z
//   out_if : one 24-bit noise_value in [0,1) per point, in input order
//   cfg_if : writes the 32-bit hash seed; always ready, write only while idle
// Timing
//   13 register stages, at most one multiply deep each (lattice multiply,
//   three hash rounds of two multiplies, ease multiplies, three blend levels).
//   A result shows on out_if once its point has passed every stage; one point
//   is taken and one result given per cycle when the receiver keeps up.
// Stalls
//   each stage advances when it is empty or its successor advances, so a
//   stalled receiver holds the last stage while bubbles further up are
//   squeezed out; in_if.ready drops only with all 13 stages full.
// Reset
//   rst_ni clears all stage valid bits and sets the seed to zero.
`default_nettype none

module value_noise_3d_core import vn3_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vn3_in_if.sink      in_if,
  vn3_out_if.source   out_if,
  vn3_cfg_if.sink     cfg_if
);

  localparam int unsigned NS = 13;                       // pipeline depth
  localparam int unsigned WW = FRAC_BITS + 2;            // ease weight term width
  localparam int unsigned PW = FRAC_BITS + NOISE_W + 2;  // blend product width

  // ---------------------------------------------------------------- helpers
  function automatic logic signed [PW-1:0] blend_prod(
    input logic [FRAC_BITS-1:0] s,
    input logic [NOISE_W-1:0]   a,
    input logic [NOISE_W-1:0]   b
  );
    logic signed [NOISE_W:0]   d;
    logic signed [FRAC_BITS:0] ws;
    d  = $signed({1'b0, b}) - $signed({1'b0, a});
    ws = $signed({1'b0, s});
    return PW'(ws * d);
  endfunction

  function automatic logic [NOISE_W-1:0] blend_sum(
    input logic [NOISE_W-1:0]   a,
    input logic signed [PW-1:0] p
  );
    logic signed [PW-1:0] q;
    q = p >>> FRAC_BITS;
    return a + NOISE_W'(q);
  endfunction

  // ---------------------------------------------------------------- control
  logic [NS:1]   v_q;
  logic [NS:1]   v_src;
  logic [NS+1:1] stage_adv;
  logic [HASH_W-1:0] seed_q;

  // a stage moves when empty or when the next one moves
  always_comb begin
    stage_adv[NS+1] = out_if.ready;
    for (int k = NS; k >= 1; k--) begin
      stage_adv[k] = !v_q[k] || stage_adv[k+1];
    end
  end

  assign v_src       = {v_q[NS-1:1], in_if.valid};
  assign in_if.ready = stage_adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NS; k++) begin
        if (stage_adv[k]) begin
          v_q[k] <= v_src[k];
        end
      end
    end
  end

  // seed register
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
    end else if (cfg_if.valid) begin
      seed_q <= cfg_if.noise_seed;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [2:0][COORD_W-1:0]   coord;
  logic [2:0][HASH_W-1:0]    lat0;
  logic [2:0][HASH_W-1:0]    lat1;
  logic [2:0][FRAC_BITS-1:0] frac;
  logic [2:0][2*FRAC_BITS-1:0] fsq;
  logic [2:0][WW-1:0]        wterm;

  logic [1:0][HASH_W-1:0]    mx_q;
  logic [HASH_W-1:0]         my_q [1:3][2];
  logic [HASH_W-1:0]         mz_q [1:5][2];
  logic [2:0][FRAC_BITS-1:0] q1_q;
  logic [2:0][WW-1:0]        w1_q;

  assign coord = {in_if.coord_z, in_if.coord_y, in_if.coord_x};

  // lattice corners and fractions per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lat0[a]  = HASH_W'($signed(coord[a]) >>> FRAC_BITS);
      lat1[a]  = lat0[a] + HASH_W'(1);
      frac[a]  = coord[a][FRAC_BITS-1:0];
      fsq[a]   = (2*FRAC_BITS)'(frac[a]) * (2*FRAC_BITS)'(frac[a]);
      wterm[a] = (WW'(3) << FRAC_BITS) - WW'({frac[a], 1'b0});
    end
  end

  // lattice products, then carried along to their hash round
  always_ff @(posedge clk_i) begin
    if (stage_adv[1]) begin
      mx_q[0]    <= lat0[0] * AXIS_K_X;
      mx_q[1]    <= lat1[0] * AXIS_K_X;
      my_q[1][0] <= lat0[1] * AXIS_K_Y;
      my_q[1][1] <= lat1[1] * AXIS_K_Y;
      mz_q[1][0] <= lat0[2] * AXIS_K_Z;
      mz_q[1][1] <= lat1[2] * AXIS_K_Z;
      for (int a = 0; a < 3; a++) begin
        q1_q[a] <= fsq[a][2*FRAC_BITS-1:FRAC_BITS];
        w1_q[a] <= wterm[a];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (stage_adv[k]) my_q[k] <= my_q[k-1];
    end
    for (int k = 2; k <= 5; k++) begin
      if (stage_adv[k]) mz_q[k] <= mz_q[k-1];
    end
  end

  // ---------------------------------------------------------------- ease weights
  logic [2:0][2*FRAC_BITS+1:0] ease_prod;
  logic [FRAC_BITS-1:0] sx_q [2:7];
  logic [FRAC_BITS-1:0] sy_q [2:9];
  logic [FRAC_BITS-1:0] sz_q [2:11];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      ease_prod[a] = (2*FRAC_BITS+2)'(q1_q[a]) * (2*FRAC_BITS+2)'(w1_q[a]);
    end
  end

  // weights ride along to where they are used
  always_ff @(posedge clk_i) begin
    if (stage_adv[2]) begin
      sx_q[2] <= ease_prod[0][2*FRAC_BITS-1:FRAC_BITS];
      sy_q[2] <= ease_prod[1][2*FRAC_BITS-1:FRAC_BITS];
      sz_q[2] <= ease_prod[2][2*FRAC_BITS-1:FRAC_BITS];
    end
    for (int k = 3; k <= 7; k++) begin
      if (stage_adv[k]) sx_q[k] <= sx_q[k-1];
    end
    for (int k = 3; k <= 9; k++) begin
      if (stage_adv[k]) sy_q[k] <= sy_q[k-1];
    end
    for (int k = 3; k <= 11; k++) begin
      if (stage_adv[k]) sz_q[k] <= sz_q[k-1];
    end
  end

  // ---------------------------------------------------------------- hash rounds
  logic [HASH_W-1:0] hx [2];
  logic [HASH_W-1:0] hy [4];
  logic [HASH_W-1:0] hz [8];

  // x round, stages 2 and 3
  for (genvar j = 0; j < 2; j++) begin : g_round_x
    vn3_hash_round u_round (
      .clk_i (clk_i),
      .en_i  ('{mul1_en: stage_adv[2], mul2_en: stage_adv[3]}),
      .a_i   (seed_q ^ mx_q[j]),
      .h_o   (hx[j])
    );
  end

  // y round, stages 4 and 5; index bit 0 is x, bit 1 is y
  for (genvar j = 0; j < 4; j++) begin : g_round_y
    vn3_hash_round u_round (
      .clk_i (clk_i),
      .en_i  ('{mul1_en: stage_adv[4], mul2_en: stage_adv[5]}),
      .a_i   (hx[j % 2] ^ my_q[3][j / 2]),
      .h_o   (hy[j])
    );
  end

  // z round, stages 6 and 7; index bit 2 is z
  for (genvar j = 0; j < 8; j++) begin : g_round_z
    vn3_hash_round u_round (
      .clk_i (clk_i),
      .en_i  ('{mul1_en: stage_adv[6], mul2_en: stage_adv[7]}),
      .a_i   (hy[j % 4] ^ mz_q[5][j / 4]),
      .h_o   (hz[j])
    );
  end

  // ---------------------------------------------------------------- blend along x
  logic [NOISE_W-1:0]         a8_q [4];
  logic signed [PW-1:0]       p8_q [4];
  logic [NOISE_W-1:0]         e9_q [4];

  always_ff @(posedge clk_i) begin
    if (stage_adv[8]) begin
      for (int j = 0; j < 4; j++) begin
        a8_q[j] <= hz[2*j][NOISE_W-1:0];
        p8_q[j] <= blend_prod(sx_q[7], hz[2*j][NOISE_W-1:0], hz[2*j+1][NOISE_W-1:0]);
      end
    end
    if (stage_adv[9]) begin
      for (int j = 0; j < 4; j++) begin
        e9_q[j] <= blend_sum(a8_q[j], p8_q[j]);
      end
    end
  end

  // ---------------------------------------------------------------- blend along y
  logic [NOISE_W-1:0]   a10_q [2];
  logic signed [PW-1:0] p10_q [2];
  logic [NOISE_W-1:0]   f11_q [2];

  always_ff @(posedge clk_i) begin
    if (stage_adv[10]) begin
      for (int j = 0; j < 2; j++) begin
        a10_q[j] <= e9_q[2*j];
        p10_q[j] <= blend_prod(sy_q[9], e9_q[2*j], e9_q[2*j+1]);
      end
    end
    if (stage_adv[11]) begin
      for (int j = 0; j < 2; j++) begin
        f11_q[j] <= blend_sum(a10_q[j], p10_q[j]);
      end
    end
  end

  // ---------------------------------------------------------------- blend along z
  logic [NOISE_W-1:0]   a12_q;
  logic signed [PW-1:0] p12_q;
  logic [NOISE_W-1:0]   r_q;

  always_ff @(posedge clk_i) begin
    if (stage_adv[12]) begin
      a12_q <= f11_q[0];
      p12_q <= blend_prod(sz_q[11], f11_q[0], f11_q[1]);
    end
    if (stage_adv[13]) begin
      r_q <= blend_sum(a12_q, p12_q);
    end
  end

  // output register drives the result channel
  assign out_if.valid       = v_q[NS];
  assign out_if.noise_value = r_q;

  // ---------------------------------------------------------------- assertions
  // an accepted point always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> v_q[1])
    else $error("accepted point not captured in first stage");

  // input backpressure only with every stage occupied
  a_full_before_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (&v_q) && !out_if.ready)
    else $error("input stalled while pipeline has a bubble");

  // a blocked next-to-last stage keeps its item
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[NS-1] && !stage_adv[NS] |=> v_q[NS-1] && $stable(a12_q) && $stable(p12_q))
    else $error("stalled stage lost or changed its item");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// testbench for value_noise_3d_core: directed and random points checked against a local predictor
module tb_top;
  import vn3_pkg::*;

  // fraction bits of the instance and the hash constants of the noise function
  localparam int unsigned FB          = FRAC_BITS_DEF;
  localparam logic [31:0] LAT_MUL_X   = 32'h27d4eb2d;
  localparam logic [31:0] LAT_MUL_Y   = 32'h165667b1;
  localparam logic [31:0] LAT_MUL_Z   = 32'h9e3779b9;
  localparam logic [31:0] AVAL_MUL_A  = 32'h7feb352d;
  localparam logic [31:0] AVAL_MUL_B  = 32'h846ca68b;
  localparam logic [31:0] CORNER_MASK = 32'h00ffffff;
  localparam logic [31:0] FRAC_MASK   = (32'd1 << FB) - 32'd1;
  localparam int unsigned RUN_LIMIT   = 4000000;

  logic clk_i;
  logic rst_ni;

  vn3_in_if  pt_ch ();
  vn3_out_if nv_ch ();
  vn3_cfg_if seed_ch ();

  value_noise_3d_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (pt_ch),
    .out_if(nv_ch),
    .cfg_if(seed_ch)
  );

  // expected noise values in request order, and the seed the block holds
  logic [NOISE_W-1:0] noise_exp_q[$];
  logic [NOISE_W-1:0] noise_want;
  logic [31:0]        cur_seed;
  int unsigned        err_count;
  bit                 idle_on;
  int unsigned        stall_left;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(RUN_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] avalanche_mix(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * AVAL_MUL_A;
    v = v ^ (v >> 15);
    v = v * AVAL_MUL_B;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic longint corner_hash(input logic [31:0] lx, ly, lz, seed);
    logic [31:0] h;
    h = avalanche_mix(seed ^ (lx * LAT_MUL_X));
    h = avalanche_mix(h ^ (ly * LAT_MUL_Y));
    h = avalanche_mix(h ^ (lz * LAT_MUL_Z));
    return longint'(h & CORNER_MASK);
  endfunction

  // floor of the coordinate, sign extended
  function automatic logic [31:0] cell_of(input logic [31:0] raw);
    return $signed(raw) >>> FB;
  endfunction

  // smoothstep weight of the fraction, truncated at each product
  function automatic longint smooth_weight(input logic [31:0] raw);
    longint f, q, w;
    f = longint'(raw & FRAC_MASK);
    q = (f * f) >> FB;
    w = (longint'(3) << FB) - 2 * f;
    return (q * w) >> FB;
  endfunction

  // lerp with the product floored toward minus infinity
  function automatic longint lerp_floor(input longint a, b, s);
    longint p;
    p = s * (b - a);
    return a + (p >>> FB);
  endfunction

  function automatic logic [NOISE_W-1:0] predict_noise(input logic [31:0] x, y, z, seed);
    logic [31:0] x0, y0, z0, x1, y1, z1;
    longint sx, sy, sz, e00, e10, e01, e11, f0, f1, r;
    x0 = cell_of(x);
    y0 = cell_of(y);
    z0 = cell_of(z);
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    z1 = z0 + 32'd1;
    sx = smooth_weight(x);
    sy = smooth_weight(y);
    sz = smooth_weight(z);
    e00 = lerp_floor(corner_hash(x0, y0, z0, seed), corner_hash(x1, y0, z0, seed), sx);
    e10 = lerp_floor(corner_hash(x0, y1, z0, seed), corner_hash(x1, y1, z0, seed), sx);
    e01 = lerp_floor(corner_hash(x0, y0, z1, seed), corner_hash(x1, y0, z1, seed), sx);
    e11 = lerp_floor(corner_hash(x0, y1, z1, seed), corner_hash(x1, y1, z1, seed), sx);
    f0 = lerp_floor(e00, e10, sy);
    f1 = lerp_floor(e01, e11, sy);
    r  = lerp_floor(f0, f1, sz);
    return r[NOISE_W-1:0];
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && nv_ch.valid === 1'b1 && nv_ch.ready === 1'b1) begin
      if (noise_exp_q.size() == 0) begin
        report_mismatch($sformatf("noise_value %h with no request pending", nv_ch.noise_value));
      end else begin
        noise_want = noise_exp_q.pop_front();
        if (nv_ch.noise_value !== noise_want)
          report_mismatch($sformatf("noise_value got %h want %h", nv_ch.noise_value,
                                    noise_want));
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    nv_ch.ready = 1'b0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        nv_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 4) - 1;
        nv_ch.ready <= 1'b0;
      end else begin
        nv_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // one point request, with an optional idle burst in front
  task automatic send_point(input logic [31:0] x, y, z);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      pt_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pt_ch.valid   <= 1'b1;
    pt_ch.coord_x <= x;
    pt_ch.coord_y <= y;
    pt_ch.coord_z <= z;
    do @(posedge clk_i); while (pt_ch.ready !== 1'b1);
    noise_exp_q.insert(noise_exp_q.size(), predict_noise(x, y, z, cur_seed));
  endtask

  // stop sending and wait for every pending result
  task automatic drain_results();
    @(negedge clk_i);
    pt_ch.valid <= 1'b0;
    while (noise_exp_q.size() != 0) @(negedge clk_i);
  endtask

  // seed write, only with the pipeline empty
  task automatic write_seed(input logic [31:0] value);
    drain_results();
    @(negedge clk_i);
    seed_ch.valid      <= 1'b1;
    seed_ch.noise_seed <= value;
    do @(posedge clk_i); while (seed_ch.ready !== 1'b1);
    cur_seed = value;
    @(negedge clk_i);
    seed_ch.valid <= 1'b0;
  endtask

  // random coordinate, biased toward cell edges, the origin and the range ends
  function automatic logic [31:0] rand_coord();
    logic [31:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: c = $urandom;
      4, 5:       c = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      6:          c = $urandom & ~FRAC_MASK;
      7:          c = $urandom | FRAC_MASK;
      8: begin
        case ($urandom_range(0, 4))
          0:       c = 32'h7fff_ffff;
          1:       c = 32'h8000_0000;
          2:       c = 32'hffff_ffff;
          3:       c = 32'h0000_0000;
          default: c = 32'h7fff_ffff - $urandom_range(0, 32'h0002_0000);
        endcase
      end
      default:    c = 32'h8000_0000 + $urandom_range(0, 32'h0002_0000);
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------- tests

  // range ends, cell edges and the wrapping +1 corner, at the reset seed
  task automatic test_directed_points();
    send_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_point(FRAC_MASK, FRAC_MASK, FRAC_MASK);
    send_point(32'd1 << FB, 32'd1 << FB, 32'd1 << FB);
    send_point(32'd1 << (FB - 1), 32'd1 << (FB - 1), 32'd1 << (FB - 1));
    send_point(32'hffff_ffff & ~FRAC_MASK, 32'h0000_0001, 32'h8000_0000 | FRAC_MASK);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff & ~FRAC_MASK);
    send_point(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
    send_point(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);
    send_point(32'h0000_8000, 32'hffff_8000, 32'h0001_8000);
  endtask

  // a handful of points under the extreme seeds and a random one
  task automatic test_seed_settings();
    logic [31:0] seeds[5];
    seeds = '{32'hffff_ffff, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001, $urandom};
    foreach (seeds[i]) begin
      write_seed(seeds[i]);
      send_point(32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff);
      repeat (30) send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // long random stream with idling, seed changes and one full pause
  task automatic test_random_stream(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_point(rand_coord(), rand_coord(), rand_coord());
      if (i == count / 2) drain_results();
      if (i % 200 == 199) write_seed($urandom);
    end
  endtask

  // back to back requests with the receiver always ready
  task automatic test_full_rate(input int unsigned count);
    idle_on = 1'b0;
    write_seed(32'hffff_ffff);
    for (int unsigned i = 0; i < count; i++)
      send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni             = 1'b0;
    pt_ch.valid        = 1'b0;
    pt_ch.coord_x      = '0;
    pt_ch.coord_y      = '0;
    pt_ch.coord_z      = '0;
    seed_ch.valid      = 1'b0;
    seed_ch.noise_seed = '0;
    cur_seed           = '0;
    err_count          = 0;
    idle_on            = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_points();
    test_seed_settings();
    test_random_stream(800);
    test_full_rate(150);

    // wait for the tail, then keep watching for anything unexpected
    drain_results();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
